>>> rtl/sspi_config_slave_sequence_checker_core_macros.svh
// Assertion macros shared by the checker.
`ifndef SSPI_CONFIG_SLAVE_SEQUENCE_CHECKER_CORE_MACROS_SVH
`define SSPI_CONFIG_SLAVE_SEQUENCE_CHECKER_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SSPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define SSPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/sspi_pkg.sv
// ----------------------------------------------------------------------------
// sspi_pkg
// Types and constants of the serial configuration port sequence checker.
// ----------------------------------------------------------------------------
package sspi_pkg;

   typedef struct packed {
      logic [2:0] func;
      logic       mosi_bit;
   } req_type;

   typedef struct packed {
      logic       miso_bit;
      logic       done_pin;
      logic [3:0] event_code;
      logic [7:0] event_byte;
      logic [2:0] expected_phase;
      logic       last_of_run;
   } rsp_type;

   // One classified request: pin levels plus up to two events.
   typedef struct packed {
      logic       miso;
      logic       done;
      logic [1:0] ev_n;
      logic [3:0] code0;
      logic [7:0] byte0;
      logic [2:0] phase0;
      logic [3:0] code1;
      logic [7:0] byte1;
      logic [2:0] phase1;
   } job_type;

   localparam logic [2:0] FUNC_SCK      = 3'd0;
   localparam logic [2:0] FUNC_SELECT   = 3'd1;
   localparam logic [2:0] FUNC_DESELECT = 3'd2;
   localparam logic [2:0] FUNC_RESET    = 3'd3;
   localparam logic [2:0] FUNC_TICK     = 3'd4;

   localparam logic [1:0] CSR_MIN_ERASE  = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_ID_CODE    = 2'd2;
   localparam logic [1:0] CSR_STAT_INDEX = 2'd3;

   localparam logic [7:0] CMD_STATUS     = 8'h41;
   localparam logic [7:0] CMD_ID         = 8'h11;
   localparam logic [7:0] CMD_WR_ENABLE  = 8'h15;
   localparam logic [7:0] CMD_BULK_ERASE = 8'h05;
   localparam logic [7:0] CMD_INIT       = 8'h12;
   localparam logic [7:0] CMD_WRITE      = 8'h3B;
   localparam logic [7:0] CMD_WR_DISABLE = 8'h3A;
   localparam logic [7:0] CMD_FILL0      = 8'hFF;
   localparam logic [7:0] CMD_FILL1      = 8'hFE;
   localparam logic [7:0] STAT_DONE      = 8'h02;

   localparam logic [2:0] BUS_IDLE  = 3'd0;
   localparam logic [2:0] BUS_CMD   = 3'd1;
   localparam logic [2:0] BUS_DUMMY = 3'd2;
   localparam logic [2:0] BUS_BURST = 3'd3;
   localparam logic [2:0] BUS_ID    = 3'd4;
   localparam logic [2:0] BUS_STAT  = 3'd5;

   localparam logic [2:0] PR_IDLE    = 3'd0;
   localparam logic [2:0] PR_ERASED  = 3'd1;
   localparam logic [2:0] PR_INIT    = 3'd2;
   localparam logic [2:0] PR_WWAIT   = 3'd3;
   localparam logic [2:0] PR_WRITING = 3'd4;

   localparam logic [3:0] EV_NONE    = 4'd0;
   localparam logic [3:0] EV_ENABLE  = 4'd1;
   localparam logic [3:0] EV_ERASE   = 4'd2;
   localparam logic [3:0] EV_INIT    = 4'd3;
   localparam logic [3:0] EV_ID      = 4'd4;
   localparam logic [3:0] EV_STATUS  = 4'd5;
   localparam logic [3:0] EV_WRITE   = 4'd6;
   localparam logic [3:0] EV_DISABLE = 4'd7;
   localparam logic [3:0] EV_UNKNOWN = 4'd8;
   localparam logic [3:0] EV_SEQ     = 4'd9;
   localparam logic [3:0] EV_TIMING  = 4'd10;
   localparam logic [3:0] EV_RESET   = 4'd11;
   localparam logic [3:0] EV_DONE    = 4'd12;

endpackage

>>> rtl/sspi_config_slave_sequence_checker_core.sv
// ----------------------------------------------------------------------------
// sspi_config_slave_sequence_checker_core
// Slave serial configuration port sequence checker.
// ----------------------------------------------------------------------------
// Each accepted request (SCK edge, select, deselect, reset or tick) yields a
// pin-status response and up to two event responses, the last one flagged by
// last_of_run. The front part updates the port state in the cycle a request
// is accepted and pushes one job into a two-entry queue; the back part emits
// one response per cycle from that queue unless rsp_ready stalls it. A request
// is taken every cycle while the queue has room, so throughput is one request
// per cycle when it causes only a pin status, and one per response otherwise,
// set by the single response register. A job passes the queue, then the
// response register. Registers are to be written through the csr_ port only
// while idle; the block does not enforce it. Each index names a register.
module sspi_config_slave_sequence_checker_core #(
   parameter int TICK_WIDTH = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sspi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sspi_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic [23:0]       min_erase_ff;
   logic [31:0]       threshold_ff;
   logic [7:0]        id_code_ff;
   logic [7:0]        stat_index_ff;
   logic              full, avail, pop, take;
   sspi_pkg::job_type job, head;

   // Configuration registers are always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_erase_ff  <= 24'd192000;
         threshold_ff  <= 32'd100;
         id_code_ff    <= 8'h11;
         stat_index_ff <= 8'd6;
      end else if (csr_valid) begin
         case (csr_index)
            sspi_pkg::CSR_MIN_ERASE:  min_erase_ff  <= csr_data[23:0];
            sspi_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_data;
            sspi_pkg::CSR_ID_CODE:    id_code_ff    <= csr_data[7:0];
            sspi_pkg::CSR_STAT_INDEX: stat_index_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   sspi_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
      .clock(clock), .reset(reset), .take(take), .req(req_data),
      .min_erase_ticks(min_erase_ff), .done_byte_threshold(threshold_ff),
      .id_code_byte(id_code_ff), .status_done_byte_index(stat_index_ff),
      .job(job)
   );

   sspi_queue u_queue (
      .clock(clock), .reset(reset), .push(take), .push_job(job), .full(full),
      .pop(pop), .avail(avail), .head(head)
   );

   sspi_back u_back (
      .clock(clock), .reset(reset), .avail(avail), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_data)
   );

endmodule

>>> rtl/sspi_front.sv
// ----------------------------------------------------------------------------
// sspi_front
// Protocol state: takes each request, updates the port state and emits one
// job that lists the pin levels and events the request caused.
// ----------------------------------------------------------------------------
module sspi_front #(
   parameter int TICK_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  sspi_pkg::req_type   req,
   input  logic [23:0]         min_erase_ticks,
   input  logic [31:0]         done_byte_threshold,
   input  logic [7:0]          id_code_byte,
   input  logic [7:0]          status_done_byte_index,
   output sspi_pkg::job_type   job
);

   logic [7:0]            in_shift_ff, in_shift_in;
   logic [2:0]            bit_count_ff, bit_count_in;
   logic [7:0]            out_shift_ff, out_shift_in;
   logic [2:0]            bus_ff, bus_in;
   logic [2:0]            proto_ff, proto_in;
   logic [31:0]           bytes_ff, bytes_in;
   logic                  done_flag_ff, done_flag_in;
   logic                  done_out_ff, done_out_in;
   logic                  miso_ff, miso_in;
   logic [TICK_WIDTH-1:0] since_ff, since_in;
   logic [1:0]            ev_n;
   logic [3:0]            code [2];
   logic [7:0]            evb [2];
   logic [2:0]            evp [2];
   logic [7:0]            cmd;
   logic [31:0]           bytes_inc;
   logic [32:0]           since_wide;
   logic                  erase_short;

   // The tick count and the 24-bit register are both widened to 33 bits.
   assign since_wide  = 33'(since_ff);
   assign erase_short = since_wide < {9'd0, min_erase_ticks};

   always_comb begin
      in_shift_in  = in_shift_ff;
      bit_count_in = bit_count_ff;
      out_shift_in = out_shift_ff;
      bus_in       = bus_ff;
      proto_in     = proto_ff;
      bytes_in     = bytes_ff;
      done_flag_in = done_flag_ff;
      done_out_in  = done_out_ff;
      miso_in      = miso_ff;
      since_in     = since_ff;
      ev_n         = 2'd0;
      code[0] = sspi_pkg::EV_NONE; code[1] = sspi_pkg::EV_NONE;
      evb[0] = 8'd0; evb[1] = 8'd0; evp[0] = 3'd0; evp[1] = 3'd0;
      cmd = {in_shift_ff[6:0], req.mosi_bit};
      bytes_inc = (bytes_ff != 32'hFFFF_FFFF) ? bytes_ff + 32'd1 : bytes_ff;
      unique case (req.func)
         sspi_pkg::FUNC_SCK: begin
            in_shift_in = cmd;
            if (bus_ff == sspi_pkg::BUS_ID || bus_ff == sspi_pkg::BUS_STAT) begin
               miso_in      = out_shift_ff[7];
               out_shift_in = {out_shift_ff[6:0], 1'b0};
            end
            if (bit_count_ff != 3'd7) begin
               bit_count_in = bit_count_ff + 3'd1;
            end else begin
               bit_count_in = 3'd0;
               if (bus_ff == sspi_pkg::BUS_BURST) begin
                  bytes_in = bytes_inc;
               end else if (bus_ff == sspi_pkg::BUS_ID) begin
                  out_shift_in = 8'd0;
               end else if (bus_ff == sspi_pkg::BUS_STAT) begin
                  bytes_in = bytes_inc;
                  out_shift_in = (bytes_inc == {24'd0, status_done_byte_index} && done_flag_ff)
                                 ? sspi_pkg::STAT_DONE : 8'd0;
               end else if (bus_ff == sspi_pkg::BUS_CMD) begin
                  bus_in = sspi_pkg::BUS_DUMMY;
                  unique case (cmd)
                     sspi_pkg::CMD_BULK_ERASE: begin
                        since_in = '0; proto_in = sspi_pkg::PR_ERASED; done_flag_in = 1'b0;
                        code[0] = sspi_pkg::EV_ERASE; ev_n = 2'd1;
                     end
                     sspi_pkg::CMD_INIT: begin
                        if (proto_ff != sspi_pkg::PR_ERASED) begin
                           code[0] = sspi_pkg::EV_SEQ; evb[0] = cmd; evp[0] = proto_ff;
                           proto_in = sspi_pkg::PR_INIT;
                           code[1] = sspi_pkg::EV_INIT; ev_n = 2'd2;
                        end else if (erase_short) begin
                           code[0] = sspi_pkg::EV_TIMING;
                           code[1] = sspi_pkg::EV_INIT; ev_n = 2'd2;
                        end else begin
                           proto_in = sspi_pkg::PR_INIT;
                           code[0] = sspi_pkg::EV_INIT; ev_n = 2'd1;
                        end
                     end
                     sspi_pkg::CMD_WR_ENABLE: begin
                        if (proto_ff == sspi_pkg::PR_INIT) proto_in = sspi_pkg::PR_WWAIT;
                        code[0] = sspi_pkg::EV_ENABLE; ev_n = 2'd1;
                     end
                     sspi_pkg::CMD_WRITE: begin
                        proto_in = sspi_pkg::PR_WRITING; bytes_in = 32'd0;
                        bus_in = sspi_pkg::BUS_BURST;
                        if (proto_ff != sspi_pkg::PR_WWAIT) begin
                           code[0] = sspi_pkg::EV_SEQ; evb[0] = cmd; evp[0] = proto_ff;
                           code[1] = sspi_pkg::EV_WRITE; ev_n = 2'd2;
                        end else begin
                           code[0] = sspi_pkg::EV_WRITE; ev_n = 2'd1;
                        end
                     end
                     sspi_pkg::CMD_WR_DISABLE: begin
                        code[0] = sspi_pkg::EV_DISABLE; ev_n = 2'd1;
                        if (bytes_ff > done_byte_threshold) begin
                           done_out_in = 1'b1; done_flag_in = 1'b1;
                           code[1] = sspi_pkg::EV_DONE; ev_n = 2'd2;
                        end
                     end
                     sspi_pkg::CMD_ID: begin
                        out_shift_in = id_code_byte; bus_in = sspi_pkg::BUS_ID;
                        code[0] = sspi_pkg::EV_ID; ev_n = 2'd1;
                     end
                     sspi_pkg::CMD_STATUS: begin
                        bytes_in = 32'd0; bus_in = sspi_pkg::BUS_STAT;
                        code[0] = sspi_pkg::EV_STATUS; ev_n = 2'd1;
                     end
                     sspi_pkg::CMD_FILL0, sspi_pkg::CMD_FILL1: begin
                     end
                     default: begin
                        code[0] = sspi_pkg::EV_UNKNOWN; evb[0] = cmd; ev_n = 2'd1;
                     end
                  endcase
               end
            end
         end
         sspi_pkg::FUNC_SELECT: begin
            bus_in = sspi_pkg::BUS_CMD; bit_count_in = 3'd0; in_shift_in = 8'd0;
         end
         sspi_pkg::FUNC_DESELECT: bus_in = sspi_pkg::BUS_IDLE;
         sspi_pkg::FUNC_RESET: begin
            done_out_in = 1'b0; done_flag_in = 1'b0;
            proto_in = sspi_pkg::PR_IDLE; bus_in = sspi_pkg::BUS_IDLE;
            code[0] = sspi_pkg::EV_RESET; ev_n = 2'd1;
         end
         sspi_pkg::FUNC_TICK: begin
            if (since_ff != {TICK_WIDTH{1'b1}}) since_in = since_ff + TICK_WIDTH'(1);
         end
         default: begin
         end
      endcase
   end

   assign job = '{miso: miso_in, done: done_out_in, ev_n: ev_n,
                  code0: code[0], byte0: evb[0], phase0: evp[0],
                  code1: code[1], byte1: evb[1], phase1: evp[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_shift_ff  <= '0;
         bit_count_ff <= '0;
         out_shift_ff <= '0;
         bus_ff       <= sspi_pkg::BUS_IDLE;
         proto_ff     <= sspi_pkg::PR_IDLE;
         bytes_ff     <= '0;
         done_flag_ff <= 1'b0;
         done_out_ff  <= 1'b0;
         miso_ff      <= 1'b0;
         since_ff     <= '0;
      end else if (take) begin
         in_shift_ff  <= in_shift_in;
         bit_count_ff <= bit_count_in;
         out_shift_ff <= out_shift_in;
         bus_ff       <= bus_in;
         proto_ff     <= proto_in;
         bytes_ff     <= bytes_in;
         done_flag_ff <= done_flag_in;
         done_out_ff  <= done_out_in;
         miso_ff      <= miso_in;
         since_ff     <= since_in;
      end
   end

endmodule

>>> rtl/sspi_queue.sv
// ----------------------------------------------------------------------------
// sspi_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sspi_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sspi_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output sspi_pkg::job_type head
);

   sspi_pkg::job_type slot_ff [2];
   logic              wr_ff, rd_ff;
   logic [1:0]        cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign avail = cnt_ff != 2'd0;
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

>>> rtl/sspi_back.sv
// ----------------------------------------------------------------------------
// sspi_back
// Result sequencer: unrolls each job into its pin-status result and events,
// one result per cycle while rsp_ready allows, into a registered output.
// ----------------------------------------------------------------------------
module sspi_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              avail,
   input  sspi_pkg::job_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sspi_pkg::rsp_type rsp
);

   logic              valid_ff;
   sspi_pkg::rsp_type rsp_ff, rsp_in;
   logic [1:0]        idx_ff;
   logic              load;
   logic              last;

   assign load = avail && (!valid_ff || rsp_ready);
   assign last = idx_ff == head.ev_n;
   assign pop  = load && last;

   always_comb begin
      rsp_in.miso_bit = head.miso;
      rsp_in.done_pin = head.done;
      rsp_in.last_of_run = last;
      case (idx_ff)
         2'd1: begin
            rsp_in.event_code = head.code0; rsp_in.event_byte = head.byte0;
            rsp_in.expected_phase = head.phase0;
         end
         2'd2: begin
            rsp_in.event_code = head.code1; rsp_in.event_byte = head.byte1;
            rsp_in.expected_phase = head.phase1;
         end
         default: begin
            rsp_in.event_code = sspi_pkg::EV_NONE; rsp_in.event_byte = 8'd0;
            rsp_in.expected_phase = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/sspi_checker.sv
// ----------------------------------------------------------------------------
// sspi_checker
// Port-level checks of the sequence checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "sspi_config_slave_sequence_checker_core_macros.svh"
module sspi_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sspi_pkg::rsp_type rsp_data
);

   `SSPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   `SSPI_ASSERT_IMPL(a_code_range, clock, reset, rsp_valid, rsp_data.event_code <= sspi_pkg::EV_DONE, "event code out of range")
   `SSPI_ASSERT_IMPL(a_event_not_last, clock, reset, rsp_valid && rsp_data.event_code == sspi_pkg::EV_SEQ, !rsp_data.last_of_run, "sequence error is never the last response")
   `SSPI_ASSERT_NEXT(a_reset_idle, clock, reset, 1'b1, !($past(reset)) || !rsp_valid, "response right after reset")

endmodule

bind sspi_config_slave_sequence_checker_core sspi_checker u_sspi_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
